// File: rtl/alu8f_pkg.sv
// ----------------------------------------------------------------------------
// alu8f_pkg - shared definitions for the 8-bit ALU with flags
// Operation codes, flag bit positions and the beat structures passed
// between the top level and the ALU core.
// ----------------------------------------------------------------------------
package alu8f_pkg;

   localparam int unsigned OpWidth   = 5;
   localparam int unsigned DataWidth = 8;
   localparam int unsigned FlagWidth = 4;

   // Operation codes
   localparam logic [OpWidth-1:0] OP_ADD  = 5'd0;
   localparam logic [OpWidth-1:0] OP_ADC  = 5'd1;
   localparam logic [OpWidth-1:0] OP_SUB  = 5'd2;
   localparam logic [OpWidth-1:0] OP_SBC  = 5'd3;
   localparam logic [OpWidth-1:0] OP_AND  = 5'd4;
   localparam logic [OpWidth-1:0] OP_XOR  = 5'd5;
   localparam logic [OpWidth-1:0] OP_OR   = 5'd6;
   localparam logic [OpWidth-1:0] OP_CP   = 5'd7;
   localparam logic [OpWidth-1:0] OP_INC  = 5'd8;
   localparam logic [OpWidth-1:0] OP_DEC  = 5'd9;
   localparam logic [OpWidth-1:0] OP_RLCA = 5'd10;
   localparam logic [OpWidth-1:0] OP_RRCA = 5'd11;
   localparam logic [OpWidth-1:0] OP_RLA  = 5'd12;
   localparam logic [OpWidth-1:0] OP_RRA  = 5'd13;
   localparam logic [OpWidth-1:0] OP_DAA  = 5'd14;
   localparam logic [OpWidth-1:0] OP_CPL  = 5'd15;
   localparam logic [OpWidth-1:0] OP_SCF  = 5'd16;
   localparam logic [OpWidth-1:0] OP_CCF  = 5'd17;

   // Flag bit positions
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   // BCD correction constants
   localparam logic [DataWidth-1:0] DAA_HI_ADJ   = 8'h60;
   localparam logic [DataWidth-1:0] DAA_LO_ADJ   = 8'h06;
   localparam logic [DataWidth-1:0] DAA_HI_LIMIT = 8'h99;
   localparam logic [3:0]           DAA_LO_LIMIT = 4'h9;

   typedef struct packed {
      logic [OpWidth-1:0]   operation;
      logic [DataWidth-1:0] accumulator;
      logic [DataWidth-1:0] operand;
      logic [FlagWidth-1:0] flags_in;
   } alu_req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic [FlagWidth-1:0] flags_out;
   } alu_rsp_type;

endpackage

// File: rtl/alu8f_core.sv
// ----------------------------------------------------------------------------
// alu8f_core - combinational 8-bit ALU datapath
// Computes the result and new Z/N/H/C flags for one operation beat.
// ----------------------------------------------------------------------------
module alu8f_core
   import alu8f_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [DataWidth-1:0] a;
   logic [DataWidth-1:0] b;
   logic                 cy;
   logic                 use_cy;
   logic [DataWidth:0]   sum9;
   logic [4:0]           sum_lo;
   logic [DataWidth:0]   diff9;
   logic [4:0]           diff_lo;
   logic                 daa_hi;
   logic                 daa_lo;
   logic [DataWidth-1:0] daa_adj;
   logic [DataWidth-1:0] daa_res;
   logic [DataWidth-1:0] r;
   logic                 z_calc;
   logic [FlagWidth-1:0] f;

   assign a      = req.accumulator;
   assign b      = req.operand;
   assign cy     = req.flags_in[FLAG_C];
   assign use_cy = ((req.operation == OP_ADC) || (req.operation == OP_SBC)) ? cy : 1'b0;

   // Ninth and fifth bits carry out (add) or borrow (subtract)
   assign sum9    = {1'b0, a} + {1'b0, b} + {{DataWidth{1'b0}}, use_cy};
   assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, use_cy};
   assign diff9   = {1'b0, a} - {1'b0, b} - {{DataWidth{1'b0}}, use_cy};
   assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, use_cy};

   // Decimal adjust
   always_comb begin
      if (!req.flags_in[FLAG_N]) begin
         daa_hi  = cy || (a > DAA_HI_LIMIT);
         daa_lo  = req.flags_in[FLAG_H] || (a[3:0] > DAA_LO_LIMIT);
         daa_adj = (daa_hi ? DAA_HI_ADJ : '0) | (daa_lo ? DAA_LO_ADJ : '0);
         daa_res = a + daa_adj;
      end else begin
         daa_hi  = cy;
         daa_lo  = req.flags_in[FLAG_H];
         daa_adj = (daa_hi ? DAA_HI_ADJ : '0) | (daa_lo ? DAA_LO_ADJ : '0);
         daa_res = a - daa_adj;
      end
   end

   always_comb begin
      r = a;
      f = req.flags_in;
      case (req.operation)
         OP_ADD, OP_ADC: begin
            r = sum9[DataWidth-1:0];
            f = '0;
            f[FLAG_H] = sum_lo[4];
            f[FLAG_C] = sum9[DataWidth];
         end
         OP_SUB, OP_SBC, OP_CP: begin
            // compare keeps the accumulator but flags follow the difference
            r = (req.operation == OP_CP) ? a : diff9[DataWidth-1:0];
            f = '0;
            f[FLAG_N] = 1'b1;
            f[FLAG_H] = diff_lo[4];
            f[FLAG_C] = diff9[DataWidth];
         end
         OP_AND: begin
            r = a & b;
            f = '0;
            f[FLAG_H] = 1'b1;
         end
         OP_XOR: begin
            r = a ^ b;
            f = '0;
         end
         OP_OR: begin
            r = a | b;
            f = '0;
         end
         OP_INC: begin
            r = a + 8'd1;
            f = '0;
            f[FLAG_H] = (a[3:0] == 4'hf);
            f[FLAG_C] = cy;
         end
         OP_DEC: begin
            r = a - 8'd1;
            f = '0;
            f[FLAG_N] = 1'b1;
            f[FLAG_H] = (a[3:0] == 4'h0);
            f[FLAG_C] = cy;
         end
         OP_RLCA: begin
            r = {a[DataWidth-2:0], a[DataWidth-1]};
            f = '0;
            f[FLAG_C] = a[DataWidth-1];
         end
         OP_RRCA: begin
            r = {a[0], a[DataWidth-1:1]};
            f = '0;
            f[FLAG_C] = a[0];
         end
         OP_RLA: begin
            r = {a[DataWidth-2:0], cy};
            f = '0;
            f[FLAG_C] = a[DataWidth-1];
         end
         OP_RRA: begin
            r = {cy, a[DataWidth-1:1]};
            f = '0;
            f[FLAG_C] = a[0];
         end
         OP_DAA: begin
            r = daa_res;
            f = '0;
            f[FLAG_N] = req.flags_in[FLAG_N];
            f[FLAG_C] = daa_hi;
         end
         OP_CPL: begin
            r = ~a;
            f[FLAG_N] = 1'b1;
            f[FLAG_H] = 1'b1;
         end
         OP_SCF: begin
            f[FLAG_N] = 1'b0;
            f[FLAG_H] = 1'b0;
            f[FLAG_C] = 1'b1;
         end
         OP_CCF: begin
            f[FLAG_N] = 1'b0;
            f[FLAG_H] = 1'b0;
            f[FLAG_C] = ~cy;
         end
         default: begin
            // unused codes pass accumulator and flags through
            r = a;
            f = req.flags_in;
         end
      endcase
   end

   // Z comes from the computed value except where it is kept or forced clear
   assign z_calc = (r == '0);

   always_comb begin
      rsp.result    = r;
      rsp.flags_out = f;
      case (req.operation)
         OP_ADD, OP_ADC, OP_AND, OP_XOR, OP_OR, OP_INC, OP_DEC, OP_DAA: begin
            rsp.flags_out[FLAG_Z] = z_calc;
         end
         OP_SUB, OP_SBC, OP_CP: begin
            rsp.flags_out[FLAG_Z] = (diff9[DataWidth-1:0] == '0);
         end
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
            rsp.flags_out[FLAG_Z] = 1'b0;
         end
         default: begin
            rsp.flags_out[FLAG_Z] = f[FLAG_Z];
         end
      endcase
   end

endmodule

// File: rtl/cpu_8bit_alu_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags - 8-bit CPU ALU with Z/N/H/C flags
// Two-stage pipeline: input register, combinational ALU, result register.
// ----------------------------------------------------------------------------
// One operation is taken on every clock edge where start is high; busy is
// never asserted, so the block sustains one beat per cycle. Each result is
// registered in the input register and then the result register around the
// ALU logic, and appears on rsp_result and rsp_flags_out for exactly one
// cycle with rsp_valid high, in issue order.
// The receiver cannot hold results off and must sample them on that cycle.
module cpu_8bit_alu_with_flags
   import alu8f_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OpWidth-1:0]   req_operation,
   input  logic [DataWidth-1:0] req_accumulator,
   input  logic [DataWidth-1:0] req_operand,
   input  logic [FlagWidth-1:0] req_flags_in,
   output logic                 rsp_valid,
   output logic [DataWidth-1:0] rsp_result,
   output logic [FlagWidth-1:0] rsp_flags_out
);

   logic        stage_valid_ff;
   logic        stage_valid_in;
   alu_req_type stage_ff;
   alu_req_type stage_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   alu_rsp_type rsp_ff;
   alu_rsp_type rsp_in;

   assign busy = 1'b0;

   assign stage_valid_in        = start && !busy;
   assign stage_in.operation    = req_operation;
   assign stage_in.accumulator  = req_accumulator;
   assign stage_in.operand      = req_operand;
   assign stage_in.flags_in     = req_flags_in;
   assign rsp_valid_in          = stage_valid_ff;

   alu8f_core u_core (
      .req (stage_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      // payload advances only with a live beat
      if (stage_valid_in) begin
         stage_ff <= stage_in;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result    = rsp_ff.result;
   assign rsp_flags_out = rsp_ff.flags_out;

   // Every result beat traces back to an earlier start beat
   a_rsp_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start, 2))
      else $error("result beat without matching start");

   // Compare leaves the accumulator unchanged
   a_cp_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && stage_ff.operation == OP_CP)
      |=> rsp_ff.result == $past(stage_ff.accumulator))
      else $error("compare altered the result");

   // Subtract-class operations always set N
   a_sub_sets_n: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && (stage_ff.operation == OP_SUB || stage_ff.operation == OP_SBC
                          || stage_ff.operation == OP_CP || stage_ff.operation == OP_DEC))
      |=> rsp_ff.flags_out[FLAG_N])
      else $error("subtract without N flag");

endmodule

// File: sim/cpu_8bit_alu_with_flags_tb.sv
// ----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags_tb - self-checking bench for the 8-bit ALU
// Drives a table of hand-picked operations, then random beats with random
// gaps, and checks every result strobe against typed-in or calculated values.
// ----------------------------------------------------------------------------
module cpu_8bit_alu_with_flags_tb;
   import alu8f_pkg::*;

   localparam int unsigned RandomBeats = 1950;
   localparam int unsigned DrainCycles = 8;
   localparam logic [OpWidth-1:0] OP_SPARE_LO = 5'd18;
   localparam logic [OpWidth-1:0] OP_SPARE_HI = 5'd31;

   typedef struct packed {
      logic [OpWidth-1:0]   op;
      logic [DataWidth-1:0] acc;
      logic [DataWidth-1:0] opnd;
      logic [FlagWidth-1:0] flg;
      logic                 known;
      logic [DataWidth-1:0] res;
      logic [FlagWidth-1:0] fout;
   } alu_vector_type;

   localparam int unsigned NumVectors = 25;

   // known = 1: result and flags typed in; otherwise taken from the calculator
   alu_vector_type directed_vectors [NumVectors] = '{
      '{OP_ADD,      8'hff, 8'h01, 4'h0, 1'b1, 8'h00, 4'hb},
      '{OP_ADD,      8'h0f, 8'h01, 4'h0, 1'b1, 8'h10, 4'h2},
      '{OP_ADC,      8'hff, 8'h00, 4'h1, 1'b1, 8'h00, 4'hb},
      '{OP_ADC,      8'h3c, 8'h5a, 4'hf, 1'b0, 8'h00, 4'h0},
      '{OP_SUB,      8'h00, 8'h01, 4'h0, 1'b1, 8'hff, 4'h7},
      '{OP_SBC,      8'h00, 8'hff, 4'h1, 1'b1, 8'h00, 4'hf},
      '{OP_SBC,      8'h80, 8'h0f, 4'h0, 1'b0, 8'h00, 4'h0},
      '{OP_AND,      8'hff, 8'h00, 4'h0, 1'b1, 8'h00, 4'ha},
      '{OP_XOR,      8'h5a, 8'h5a, 4'h0, 1'b1, 8'h00, 4'h8},
      '{OP_OR,       8'hff, 8'hff, 4'hf, 1'b1, 8'hff, 4'h0},
      '{OP_CP,       8'h3c, 8'h3c, 4'h0, 1'b1, 8'h3c, 4'hc},
      '{OP_INC,      8'hff, 8'h00, 4'h1, 1'b1, 8'h00, 4'hb},
      '{OP_DEC,      8'h00, 8'h00, 4'h0, 1'b1, 8'hff, 4'h6},
      '{OP_DEC,      8'h01, 8'hff, 4'h0, 1'b1, 8'h00, 4'hc},
      '{OP_RLCA,     8'h80, 8'h00, 4'hf, 1'b1, 8'h01, 4'h1},
      '{OP_RRCA,     8'h01, 8'h00, 4'hf, 1'b1, 8'h80, 4'h1},
      '{OP_RLA,      8'h80, 8'h00, 4'h0, 1'b1, 8'h00, 4'h1},
      '{OP_RRA,      8'h01, 8'h00, 4'h0, 1'b1, 8'h00, 4'h1},
      '{OP_DAA,      8'h9a, 8'h00, 4'h0, 1'b1, 8'h00, 4'h9},
      '{OP_DAA,      8'h00, 8'h00, 4'h7, 1'b1, 8'h9a, 4'h5},
      '{OP_CPL,      8'h00, 8'h00, 4'h9, 1'b1, 8'hff, 4'hf},
      '{OP_SCF,      8'h12, 8'h00, 4'he, 1'b1, 8'h12, 4'h9},
      '{OP_CCF,      8'h34, 8'h00, 4'h9, 1'b1, 8'h34, 4'h8},
      '{OP_SPARE_LO, 8'h77, 8'h00, 4'h5, 1'b1, 8'h77, 4'h5},
      '{OP_SPARE_HI, 8'h00, 8'hff, 4'ha, 1'b1, 8'h00, 4'ha}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [OpWidth-1:0]   req_operation   = '0;
   logic [DataWidth-1:0] req_accumulator = '0;
   logic [DataWidth-1:0] req_operand     = '0;
   logic [FlagWidth-1:0] req_flags_in    = '0;
   logic                 rsp_valid;
   logic [DataWidth-1:0] rsp_result;
   logic [FlagWidth-1:0] rsp_flags_out;

   alu_rsp_type staged_result = '0;
   alu_rsp_type awaited_results [$];
   int unsigned error_count = 0;
   int unsigned busy_free_run = 0;

   cpu_8bit_alu_with_flags DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_accumulator (req_accumulator),
      .req_operand     (req_operand),
      .req_flags_in    (req_flags_in),
      .rsp_valid       (rsp_valid),
      .rsp_result      (rsp_result),
      .rsp_flags_out   (rsp_flags_out)
   );

   always #4 clock = ~clock;

   function automatic alu_rsp_type compute_alu(
      logic [OpWidth-1:0] op, logic [DataWidth-1:0] a, logic [DataWidth-1:0] b,
      logic [FlagWidth-1:0] f);
      logic                 cy;
      logic                 adj;
      logic [8:0]           wide;
      logic [4:0]           nib;
      logic [DataWidth-1:0] r;
      logic [FlagWidth-1:0] nf;
      alu_rsp_type          rsp;
      cy  = f[FLAG_C];
      r   = a;
      nf  = '0;
      case (op)
         OP_ADD, OP_ADC: begin
            adj  = (op == OP_ADC) ? cy : 1'b0;
            wide = {1'b0, a} + {1'b0, b} + {8'd0, adj};
            nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, adj};
            r = wide[7:0];
            nf[FLAG_H] = nib[4];
            nf[FLAG_C] = wide[8];
         end
         OP_SUB, OP_SBC, OP_CP: begin
            // bit 8 and bit 4 of the widened difference are the borrows
            adj  = (op == OP_SBC) ? cy : 1'b0;
            wide = {1'b0, a} - {1'b0, b} - {8'd0, adj};
            nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, adj};
            r = wide[7:0];
            nf[FLAG_N] = 1'b1;
            nf[FLAG_H] = nib[4];
            nf[FLAG_C] = wide[8];
         end
         OP_AND: begin
            r = a & b;
            nf[FLAG_H] = 1'b1;
         end
         OP_XOR: r = a ^ b;
         OP_OR:  r = a | b;
         OP_INC: begin
            r = a + 8'd1;
            nf[FLAG_H] = (a[3:0] == 4'hf);
            nf[FLAG_C] = cy;
         end
         OP_DEC: begin
            r = a - 8'd1;
            nf[FLAG_N] = 1'b1;
            nf[FLAG_H] = (a[3:0] == 4'h0);
            nf[FLAG_C] = cy;
         end
         OP_RLCA: begin
            r = {a[6:0], a[7]};
            nf[FLAG_C] = a[7];
         end
         OP_RRCA: begin
            r = {a[0], a[7:1]};
            nf[FLAG_C] = a[0];
         end
         OP_RLA: begin
            r = {a[6:0], cy};
            nf[FLAG_C] = a[7];
         end
         OP_RRA: begin
            r = {cy, a[7:1]};
            nf[FLAG_C] = a[0];
         end
         OP_DAA: begin
            adj = cy;
            if (!f[FLAG_N]) begin
               if (cy || a > DAA_HI_LIMIT) begin
                  r   = r + DAA_HI_ADJ;
                  adj = 1'b1;
               end
               if (f[FLAG_H] || a[3:0] > DAA_LO_LIMIT) r = r + DAA_LO_ADJ;
            end else begin
               if (cy) r = r - DAA_HI_ADJ;
               if (f[FLAG_H]) r = r - DAA_LO_ADJ;
            end
            nf[FLAG_N] = f[FLAG_N];
            nf[FLAG_C] = adj;
         end
         OP_CPL: begin
            r = ~a;
            nf = f;
            nf[FLAG_N] = 1'b1;
            nf[FLAG_H] = 1'b1;
         end
         OP_SCF: begin
            nf[FLAG_Z] = f[FLAG_Z];
            nf[FLAG_C] = 1'b1;
         end
         OP_CCF: begin
            nf[FLAG_Z] = f[FLAG_Z];
            nf[FLAG_C] = ~cy;
         end
         default: nf = f;
      endcase
      // zero flag follows the result except where it is kept or forced low
      case (op)
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: nf[FLAG_Z] = 1'b0;
         OP_CPL, OP_SCF, OP_CCF: ;
         OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP, OP_AND, OP_XOR, OP_OR,
         OP_INC, OP_DEC, OP_DAA: nf[FLAG_Z] = (r == 8'h00);
         default: ;
      endcase
      if (op == OP_CP) r = a;
      rsp.result    = r;
      rsp.flags_out = nf;
      return rsp;
   endfunction

   function automatic logic [DataWidth-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hff;
         2:       return {4'h0, 4'($urandom)};
         3:       return {4'($urandom), 4'hf};
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (busy_free_run > 0) begin
         busy_free_run--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         busy_free_run = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // hold the beat on the ports until an edge sees start high and busy low
   task automatic drive_beat(logic [OpWidth-1:0] op, logic [DataWidth-1:0] a,
                             logic [DataWidth-1:0] b, logic [FlagWidth-1:0] f,
                             alu_rsp_type exp_rsp);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation   <= op;
      req_accumulator <= a;
      req_operand     <= b;
      req_flags_in    <= f;
      staged_result   <= exp_rsp;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // queue the expectation of each accepted beat, then check any result strobe
   always @(posedge clock) begin
      alu_rsp_type exp_rsp;
      if (!reset && start && !busy) awaited_results.push_back(staged_result);
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $error("result with none pending: result=%h flags_out=%h",
                   rsp_result, rsp_flags_out);
            error_count++;
         end else begin
            exp_rsp = awaited_results.pop_front();
            if (rsp_result !== exp_rsp.result) begin
               $error("result: expected %h, got %h", exp_rsp.result, rsp_result);
               error_count++;
            end
            if (rsp_flags_out !== exp_rsp.flags_out) begin
               $error("flags_out: expected %h, got %h",
                      exp_rsp.flags_out, rsp_flags_out);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [OpWidth-1:0]   op;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
      logic [FlagWidth-1:0] f;
      alu_rsp_type          exp_rsp;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_vectors[i]) begin
         if (directed_vectors[i].known) begin
            exp_rsp.result    = directed_vectors[i].res;
            exp_rsp.flags_out = directed_vectors[i].fout;
         end else begin
            exp_rsp = compute_alu(directed_vectors[i].op, directed_vectors[i].acc,
                                  directed_vectors[i].opnd, directed_vectors[i].flg);
         end
         drive_beat(directed_vectors[i].op, directed_vectors[i].acc,
                    directed_vectors[i].opnd, directed_vectors[i].flg, exp_rsp);
      end

      for (int unsigned n = 0; n < RandomBeats; n++) begin
         // mostly defined codes, now and then a spare one
         if ($urandom_range(0, 9) != 0) op = 5'($urandom_range(0, 17));
         else op = 5'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         a = pick_byte();
         b = pick_byte();
         f = 4'($urandom);
         drive_beat(op, a, b, f, compute_alu(op, a, b, f));
      end
      start <= 1'b0;

      while (awaited_results.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
